>>> rtl/core/scc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_pkg
// Shared constants, types and the arctangent table of the CFO estimator.
// ----------------------------------------------------------------------------
package scc_pkg;

  // Delays must be powers of two and FINE_DELAY a multiple of four.
  localparam int FINE_DELAY   = 64;
  localparam int MAX_ANTENNAS = 4;
  localparam int SAMPLE_BITS  = 16;
  localparam int CORDIC_STEPS = 16;

  localparam int COARSE_DELAY = FINE_DELAY / 4;
  localparam int ADDR_W       = $clog2(FINE_DELAY);
  localparam int POS_W        = 9;
  localparam int ACC_W        = 42;
  localparam int WIN_W        = 8;
  localparam int FS_W         = 27;
  localparam int ANT_W        = 2;
  localparam int CFO_W        = 23;
  localparam int CFG_IDX_W    = 1;

  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int TERM_W = PROD_W + 1;
  localparam int LO_W   = ACC_W / 2;
  localparam int HI_W   = ACC_W - LO_W;
  localparam int SQ_W   = 2 * ACC_W;

  localparam int CW      = ACC_W + 4;
  localparam int ANG_W   = 34;
  localparam int SUMA_W  = ANG_W + 2;
  localparam int AMAG_W  = SUMA_W - 1;
  localparam int AM_LO   = AMAG_W / 2;
  localparam int N_W     = AMAG_W + FS_W;
  localparam int DEN_SHIFT = $clog2(FINE_DELAY) + 32;

  localparam int OUT_FIFO_DEPTH = 32;
  localparam int FPTR_W = $clog2(OUT_FIFO_DEPTH);
  localparam int FCNT_W = FPTR_W + 1;

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(64);
  localparam logic [FS_W-1:0]  FS_RESET  = FS_W'(20000000);
  localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(64'sh8000_0000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW = 1'b0,
    CFG_FS     = 1'b1
  } cfg_idx_t;

  // Row snapshot at row end, also used for the block winner.
  typedef struct packed {
    logic                    valid;
    logic                    last_block;
    logic                    coarse;
    logic [ANT_W-1:0]        antenna;
    logic signed [ACC_W-1:0] s_re;
    logic signed [ACC_W-1:0] s_im;
    logic signed [ACC_W-1:0] l_re;
    logic signed [ACC_W-1:0] l_im;
  } row_t;

  typedef struct packed {
    logic                    valid;
    logic                    coarse;
    logic [ANT_W-1:0]        antenna;
    logic signed [ANG_W-1:0] a1;
    logic signed [ANG_W-1:0] a2;
  } ang_t;

  typedef struct packed {
    logic                    valid;
    logic signed [CFO_W-1:0] cfo;
    logic [ANT_W-1:0]        antenna;
  } res_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [ANG_W-1:0] turn_atan(input int i);
    logic signed [ANG_W-1:0] r;
    case (i)
      0:  r = ANG_W'(536870912);
      1:  r = ANG_W'(316933406);
      2:  r = ANG_W'(167458907);
      3:  r = ANG_W'(85004756);
      4:  r = ANG_W'(42667331);
      5:  r = ANG_W'(21354465);
      6:  r = ANG_W'(10679838);
      7:  r = ANG_W'(5340245);
      8:  r = ANG_W'(2670163);
      9:  r = ANG_W'(1335087);
      10: r = ANG_W'(667544);
      11: r = ANG_W'(333772);
      12: r = ANG_W'(166886);
      13: r = ANG_W'(83443);
      14: r = ANG_W'(41722);
      15: r = ANG_W'(20861);
      16: r = ANG_W'(10430);
      17: r = ANG_W'(5215);
      18: r = ANG_W'(2608);
      19: r = ANG_W'(1304);
      20: r = ANG_W'(652);
      21: r = ANG_W'(326);
      22: r = ANG_W'(163);
      23: r = ANG_W'(81);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/scc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_if
// Handshake channels of the CFO estimator: samples, results, configuration.
// ----------------------------------------------------------------------------
interface scc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [scc_pkg::SAMPLE_BITS-1:0] sample_re;
  logic signed [scc_pkg::SAMPLE_BITS-1:0] sample_im;
  logic [scc_pkg::ANT_W-1:0]             antenna;
  logic                                  coarse_mode;
  logic                                  last_in_row;
  logic                                  last_in_block;

  modport source (output valid, sample_re, sample_im, antenna, coarse_mode,
                  last_in_row, last_in_block, input ready);
  modport sink   (input valid, sample_re, sample_im, antenna, coarse_mode,
                  last_in_row, last_in_block, output ready);
endinterface

interface scc_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [scc_pkg::CFO_W-1:0] cfo_hz;
  logic [scc_pkg::ANT_W-1:0]       selected_antenna;

  modport source (output valid, cfo_hz, selected_antenna, input ready);
  modport sink   (input valid, cfo_hz, selected_antenna, output ready);
endinterface

interface scc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [scc_pkg::CFG_IDX_W-1:0] index;
  logic [scc_pkg::FS_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/scc_delay_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_delay_mem
// Sample delay line: one write port, two registered read ports (read-old).
// ----------------------------------------------------------------------------
module scc_delay_mem (
  input  logic                                clk,
  input  logic                                we,
  input  logic [scc_pkg::ADDR_W-1:0]          waddr,
  input  logic [2*scc_pkg::SAMPLE_BITS-1:0]   wdata,
  input  logic [scc_pkg::ADDR_W-1:0]          raddr_s,
  input  logic [scc_pkg::ADDR_W-1:0]          raddr_l,
  output logic [2*scc_pkg::SAMPLE_BITS-1:0]   rdata_s_r,
  output logic [2*scc_pkg::SAMPLE_BITS-1:0]   rdata_l_r
);

  logic [2*scc_pkg::SAMPLE_BITS-1:0] mem_r [scc_pkg::FINE_DELAY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_s_r <= mem_r[raddr_s];
    rdata_l_r <= mem_r[raddr_l];
  end

endmodule

>>> rtl/core/scc_corr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_corr
// Row position, delay-line access and the two delayed autocorrelation sums.
// ----------------------------------------------------------------------------
module scc_corr (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   accept,
  input  logic signed [scc_pkg::SAMPLE_BITS-1:0] sample_re,
  input  logic signed [scc_pkg::SAMPLE_BITS-1:0] sample_im,
  input  logic [scc_pkg::ANT_W-1:0]              antenna,
  input  logic                                   coarse_mode,
  input  logic                                   last_in_row,
  input  logic                                   last_in_block,
  input  logic [scc_pkg::WIN_W-1:0]              window_length,
  output scc_pkg::row_t                          row_o
);

  localparam int SB = scc_pkg::SAMPLE_BITS;
  localparam int PW = scc_pkg::POS_W;

  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] d1, win, off_s, off_l;
  logic          en_s, en_l;

  logic [2*SB-1:0] rdata_s, rdata_l;

  // stage 1: memory data arrives
  logic                           v1_r, es1_r, el1_r, re1_r, lb1_r, cm1_r;
  logic [scc_pkg::ANT_W-1:0]      ant1_r;
  logic signed [SB-1:0]           br1_r, bi1_r;
  logic signed [SB-1:0]           ar_s, ai_s, ar_l, ai_l;

  // stage 2: products
  logic                           v2_r, es2_r, el2_r, re2_r, lb2_r, cm2_r;
  logic [scc_pkg::ANT_W-1:0]      ant2_r;
  logic signed [scc_pkg::PROD_W-1:0] prr_s_r, pii_s_r, pir_s_r, pri_s_r;
  logic signed [scc_pkg::PROD_W-1:0] prr_l_r, pii_l_r, pir_l_r, pri_l_r;

  logic signed [scc_pkg::TERM_W-1:0] t_re_s, t_im_s, t_re_l, t_im_l;
  logic signed [scc_pkg::ACC_W-1:0]  acc_s_re_r, acc_s_im_r, acc_l_re_r, acc_l_im_r;
  logic signed [scc_pkg::ACC_W-1:0]  sum_s_re, sum_s_im, sum_l_re, sum_l_im;
  scc_pkg::row_t                     row_r;

  always_comb begin
    d1    = coarse_mode ? PW'(scc_pkg::COARSE_DELAY) : PW'(scc_pkg::FINE_DELAY);
    win   = coarse_mode ? PW'(window_length) + PW'(scc_pkg::COARSE_DELAY)
                        : PW'(window_length);
    off_s = pos_r - d1;
    off_l = pos_r - PW'(2 * scc_pkg::COARSE_DELAY);
    en_s  = (pos_r >= d1) && (off_s < win);
    en_l  = coarse_mode && (pos_r >= PW'(2 * scc_pkg::COARSE_DELAY)) && (off_l < win);
    pos_nxt = pos_r;
    if (accept) begin
      pos_nxt = (last_in_row || last_in_block) ? '0 : pos_r + 1'b1;
    end
  end

  scc_delay_mem u_mem (
    .clk       (clk),
    .we        (accept),
    .waddr     (pos_r[scc_pkg::ADDR_W-1:0]),
    .wdata     ({sample_re, sample_im}),
    .raddr_s   (off_s[scc_pkg::ADDR_W-1:0]),
    .raddr_l   (off_l[scc_pkg::ADDR_W-1:0]),
    .rdata_s_r (rdata_s),
    .rdata_l_r (rdata_l)
  );

  assign ar_s = rdata_s[2*SB-1:SB];
  assign ai_s = rdata_s[SB-1:0];
  assign ar_l = rdata_l[2*SB-1:SB];
  assign ai_l = rdata_l[SB-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      v1_r  <= accept;
      v2_r  <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    es1_r  <= en_s;
    el1_r  <= en_l;
    re1_r  <= last_in_row || last_in_block;
    lb1_r  <= last_in_block;
    cm1_r  <= coarse_mode;
    ant1_r <= antenna;
    br1_r  <= sample_re;
    bi1_r  <= sample_im;

    es2_r   <= es1_r;
    el2_r   <= el1_r;
    re2_r   <= re1_r;
    lb2_r   <= lb1_r;
    cm2_r   <= cm1_r;
    ant2_r  <= ant1_r;
    prr_s_r <= ar_s * br1_r;
    pii_s_r <= ai_s * bi1_r;
    pir_s_r <= ai_s * br1_r;
    pri_s_r <= ar_s * bi1_r;
    prr_l_r <= ar_l * br1_r;
    pii_l_r <= ai_l * bi1_r;
    pir_l_r <= ai_l * br1_r;
    pri_l_r <= ar_l * bi1_r;
  end

  // a * conj(b): re = ar*br + ai*bi, im = ai*br - ar*bi
  always_comb begin
    t_re_s = scc_pkg::TERM_W'(prr_s_r) + scc_pkg::TERM_W'(pii_s_r);
    t_im_s = scc_pkg::TERM_W'(pir_s_r) - scc_pkg::TERM_W'(pri_s_r);
    t_re_l = scc_pkg::TERM_W'(prr_l_r) + scc_pkg::TERM_W'(pii_l_r);
    t_im_l = scc_pkg::TERM_W'(pir_l_r) - scc_pkg::TERM_W'(pri_l_r);
    sum_s_re = es2_r ? acc_s_re_r + scc_pkg::ACC_W'(t_re_s) : acc_s_re_r;
    sum_s_im = es2_r ? acc_s_im_r + scc_pkg::ACC_W'(t_im_s) : acc_s_im_r;
    sum_l_re = el2_r ? acc_l_re_r + scc_pkg::ACC_W'(t_re_l) : acc_l_re_r;
    sum_l_im = el2_r ? acc_l_im_r + scc_pkg::ACC_W'(t_im_l) : acc_l_im_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_s_re_r <= '0;
      acc_s_im_r <= '0;
      acc_l_re_r <= '0;
      acc_l_im_r <= '0;
      row_r      <= '0;
    end else begin
      row_r.valid <= v2_r && re2_r;
      if (v2_r && re2_r) begin
        row_r.last_block <= lb2_r;
        row_r.coarse     <= cm2_r;
        row_r.antenna    <= ant2_r;
        row_r.s_re       <= sum_s_re;
        row_r.s_im       <= sum_s_im;
        row_r.l_re       <= sum_l_re;
        row_r.l_im       <= sum_l_im;
      end
      if (v2_r) begin
        // clear at row end, else keep accumulating
        acc_s_re_r <= re2_r ? '0 : sum_s_re;
        acc_s_im_r <= re2_r ? '0 : sum_s_im;
        acc_l_re_r <= re2_r ? '0 : sum_l_re;
        acc_l_im_r <= re2_r ? '0 : sum_l_im;
      end
    end
  end

  assign row_o = row_r;

endmodule

>>> rtl/core/scc_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_select
// Squared magnitude of each row sum and best-row tracking per block.
// ----------------------------------------------------------------------------
module scc_select (
  input  logic          clk,
  input  logic          rst_n,
  input  scc_pkg::row_t row_i,
  output scc_pkg::row_t blk_o
);

  localparam int AW = scc_pkg::ACC_W;
  localparam int LW = scc_pkg::LO_W;
  localparam int HW = scc_pkg::HI_W;
  localparam int QW = scc_pkg::SQ_W;

  function automatic logic [AW-1:0] abs_mag(input logic signed [AW-1:0] v);
    return v[AW-1] ? AW'(-v) : AW'(v);
  endfunction

  scc_pkg::row_t p3_r, p4_r, p5_r, p6_r, blk_r, best_r, pick;
  logic [AW-1:0]    mag_re_r, mag_im_r;
  logic [2*HW-1:0]  hh_re_r, hh_im_r;
  logic [HW+LW-1:0] hl_re_r, hl_im_r;
  logic [2*LW-1:0]  ll_re_r, ll_im_r;
  logic [QW-1:0]    sq_re_r, sq_im_r, tot_r, best_mag_r;
  logic             gt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_r.valid <= 1'b0;
      p4_r.valid <= 1'b0;
      p5_r.valid <= 1'b0;
      p6_r.valid <= 1'b0;
    end else begin
      p3_r <= row_i;
      p4_r <= p3_r;
      p5_r <= p4_r;
      p6_r <= p5_r;
    end
  end

  always_ff @(posedge clk) begin
    mag_re_r <= abs_mag(row_i.s_re);
    mag_im_r <= abs_mag(row_i.s_im);
    hh_re_r  <= mag_re_r[AW-1:LW] * mag_re_r[AW-1:LW];
    hl_re_r  <= mag_re_r[AW-1:LW] * mag_re_r[LW-1:0];
    ll_re_r  <= mag_re_r[LW-1:0] * mag_re_r[LW-1:0];
    hh_im_r  <= mag_im_r[AW-1:LW] * mag_im_r[AW-1:LW];
    hl_im_r  <= mag_im_r[AW-1:LW] * mag_im_r[LW-1:0];
    ll_im_r  <= mag_im_r[LW-1:0] * mag_im_r[LW-1:0];
    sq_re_r  <= (QW'(hh_re_r) << (2 * LW)) + (QW'(hl_re_r) << (LW + 1)) + QW'(ll_re_r);
    sq_im_r  <= (QW'(hh_im_r) << (2 * LW)) + (QW'(hl_im_r) << (LW + 1)) + QW'(ll_im_r);
    tot_r    <= sq_re_r + sq_im_r;
  end

  // strictly larger wins, so ties keep the earlier row
  always_comb begin
    gt   = p6_r.valid && (int'(p6_r.antenna) < scc_pkg::MAX_ANTENNAS) && (tot_r > best_mag_r);
    pick = gt ? p6_r : best_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r     <= '0;
      best_mag_r <= '0;
      blk_r      <= '0;
    end else begin
      blk_r.valid <= p6_r.valid && p6_r.last_block;
      if (p6_r.valid && p6_r.last_block) begin
        blk_r.last_block <= 1'b1;
        blk_r.coarse     <= p6_r.coarse;
        blk_r.antenna    <= pick.antenna;
        blk_r.s_re       <= pick.s_re;
        blk_r.s_im       <= pick.s_im;
        blk_r.l_re       <= pick.l_re;
        blk_r.l_im       <= pick.l_im;
        best_r           <= '0;
        best_mag_r       <= '0;
      end else if (gt) begin
        best_r     <= p6_r;
        best_mag_r <= tot_r;
      end
    end
  end

  assign blk_o = blk_r;

endmodule

>>> rtl/core/scc_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_cordic
// Pipelined vectoring CORDIC on both correlation sums, one step per stage.
// ----------------------------------------------------------------------------
module scc_cordic (
  input  logic          clk,
  input  logic          rst_n,
  input  scc_pkg::row_t blk_i,
  output scc_pkg::ang_t ang_o
);

  localparam int N  = scc_pkg::CORDIC_STEPS;
  localparam int CW = scc_pkg::CW;
  localparam int ZW = scc_pkg::ANG_W;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cvec_t;

  // fold the left half-plane onto the right one
  function automatic cvec_t cpre(input logic signed [scc_pkg::ACC_W-1:0] re,
                                 input logic signed [scc_pkg::ACC_W-1:0] im);
    cvec_t r;
    r.x = CW'(re);
    r.y = CW'(im);
    r.z = '0;
    if (re < 0) begin
      r.z = (im >= 0) ? scc_pkg::HALF_TURN : -scc_pkg::HALF_TURN;
      r.x = -r.x;
      r.y = -r.y;
    end
    return r;
  endfunction

  function automatic cvec_t cstep(input cvec_t v, input int i);
    cvec_t r;
    if (v.y > 0) begin
      r.x = v.x + (v.y >>> i);
      r.y = v.y - (v.x >>> i);
      r.z = v.z + scc_pkg::turn_atan(i);
    end else begin
      r.x = v.x - (v.y >>> i);
      r.y = v.y + (v.x >>> i);
      r.z = v.z - scc_pkg::turn_atan(i);
    end
    return r;
  endfunction

  cvec_t                     vs_r [N+1];
  cvec_t                     vl_r [N+1];
  logic                      vld_r [N+1];
  logic                      crs_r [N+1];
  logic                      zs_r [N+1];
  logic                      zl_r [N+1];
  logic [scc_pkg::ANT_W-1:0] ant_r [N+1];
  scc_pkg::ang_t             ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= N; i++) begin
        vld_r[i] <= 1'b0;
      end
      ang_r <= '0;
    end else begin
      vld_r[0] <= blk_i.valid;
      for (int i = 0; i < N; i++) begin
        vld_r[i+1] <= vld_r[i];
      end
      ang_r.valid   <= vld_r[N];
      ang_r.coarse  <= crs_r[N];
      ang_r.antenna <= ant_r[N];
      // the zero vector has angle zero
      ang_r.a1      <= zs_r[N] ? '0 : vs_r[N].z;
      ang_r.a2      <= zl_r[N] ? '0 : vl_r[N].z;
    end
  end

  always_ff @(posedge clk) begin
    vs_r[0]  <= cpre(blk_i.s_re, blk_i.s_im);
    vl_r[0]  <= cpre(blk_i.l_re, blk_i.l_im);
    crs_r[0] <= blk_i.coarse;
    ant_r[0] <= blk_i.antenna;
    zs_r[0]  <= (blk_i.s_re == '0) && (blk_i.s_im == '0);
    zl_r[0]  <= (blk_i.l_re == '0) && (blk_i.l_im == '0);
    for (int i = 0; i < N; i++) begin
      vs_r[i+1]  <= cstep(vs_r[i], i);
      vl_r[i+1]  <= cstep(vl_r[i], i);
      crs_r[i+1] <= crs_r[i];
      ant_r[i+1] <= ant_r[i];
      zs_r[i+1]  <= zs_r[i];
      zl_r[i+1]  <= zl_r[i];
    end
  end

  assign ang_o = ang_r;

endmodule

>>> rtl/core/scc_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_scale
// Angle to hertz: combine angles, multiply by fs, round and saturate.
// ----------------------------------------------------------------------------
module scc_scale (
  input  logic                     clk,
  input  logic                     rst_n,
  input  scc_pkg::ang_t            ang_i,
  input  logic [scc_pkg::FS_W-1:0] fs,
  output scc_pkg::res_t            res_o
);

  localparam int SW   = scc_pkg::SUMA_W;
  localparam int MW   = scc_pkg::AMAG_W;
  localparam int LOW  = scc_pkg::AM_LO;
  localparam int PLW  = LOW + scc_pkg::FS_W;
  localparam int PHW  = MW - LOW + scc_pkg::FS_W;
  localparam int NW   = scc_pkg::N_W;
  localparam int RW   = NW + 1;
  localparam int QW   = RW - scc_pkg::DEN_SHIFT;
  localparam int CW   = scc_pkg::CFO_W;
  localparam logic [QW-1:0] LIM = QW'(1) << (CW - 1);

  logic signed [SW-1:0] a_sum;
  logic [MW-1:0]        a_mag;

  logic                      va_r, vb_r, nega_r, negb_r;
  logic [scc_pkg::ANT_W-1:0] anta_r, antb_r;
  logic [MW-1:0]             maga_r;
  logic [PLW-1:0]            plo_r;
  logic [PHW-1:0]            phi_r;

  logic [RW-1:0] rnd;
  logic [QW-1:0] q, qs, qp;
  scc_pkg::res_t res_r;

  // coarse: 2*A1 + A2 over the same denominator
  always_comb begin
    a_sum = ang_i.coarse ? (SW'(ang_i.a1) <<< 1) + SW'(ang_i.a2) : SW'(ang_i.a1);
    a_mag = a_sum[SW-1] ? MW'(-a_sum) : MW'(a_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
      res_r <= '0;
    end else begin
      va_r        <= ang_i.valid;
      vb_r        <= va_r;
      res_r.valid <= vb_r;
      // sign flip of the estimator
      res_r.cfo     <= negb_r ? CW'(qp) : CW'(-qs);
      res_r.antenna <= antb_r;
    end
  end

  always_ff @(posedge clk) begin
    nega_r <= a_sum[SW-1];
    anta_r <= ang_i.antenna;
    maga_r <= a_mag;
    negb_r <= nega_r;
    antb_r <= anta_r;
    plo_r  <= PLW'(maga_r[LOW-1:0]) * PLW'(fs);
    phi_r  <= PHW'(maga_r[MW-1:LOW]) * PHW'(fs);
  end

  // round half away from zero on the magnitude, then saturate
  always_comb begin
    rnd = (RW'(phi_r) << LOW) + RW'(plo_r) + (RW'(1) << (scc_pkg::DEN_SHIFT - 1));
    q   = rnd[RW-1:scc_pkg::DEN_SHIFT];
    qs  = (q > LIM) ? LIM : q;
    qp  = (qs == LIM) ? LIM - 1'b1 : qs;
  end

  assign res_o = res_r;

endmodule

>>> rtl/core/schmidl_cox_cfo_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// schmidl_cox_cfo_estimator
// Delayed-autocorrelation carrier frequency offset estimator with
// best-antenna selection over a block of preamble rows.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle while input is not held off by the result
//   queue; each sample does one delay-line access (one write, two registered
//   reads) and two complex MACs.
// Reset: synchronous, active low; clears sums, the kept row, row position,
//   pipeline valids and the result queue; registers return to 64 and 20 MHz.
// ----------------------------------------------------------------------------
module schmidl_cox_cfo_estimator (
  input  logic       clk,
  input  logic       rst_n,
  scc_in_if.sink     in_if,
  scc_out_if.source  out_if,
  scc_cfg_if.sink    cfg_if
);

  // Datapath:
  //   scc_corr   - row position counter, 64-entry delay line memory
  //                (write at p, read at p-D and p-2D), complex products,
  //                42-bit wrapping sums; snapshot at each row end.
  //   scc_select - exact 84-bit squared magnitude in four stages, keep the
  //                strictly largest row; hand the winner on at block end.
  //   scc_cordic - one CORDIC step per stage for both sums.
  //   scc_scale  - angle times fs split in two products, round and saturate.
  // Results land in a small queue. Input is held off only when every queue
  // slot is claimed by a block end already accepted, so the pipeline never
  // stalls and a waiting result blocks new samples only in that case.

  logic [scc_pkg::WIN_W-1:0] window_r;
  logic [scc_pkg::FS_W-1:0]  fs_r;

  logic in_fire, out_fire, push;
  logic [scc_pkg::FCNT_W-1:0] pending_r, pending_nxt;

  scc_pkg::row_t row, blk;
  scc_pkg::ang_t ang;
  scc_pkg::res_t res;

  scc_pkg::res_t              fifo_r [scc_pkg::OUT_FIFO_DEPTH];
  logic [scc_pkg::FPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [scc_pkg::FCNT_W-1:0] fcnt_r;

  // ---------------------------------------------------------------- config
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= scc_pkg::WIN_RESET;
      fs_r     <= scc_pkg::FS_RESET;
    end else if (cfg_if.valid) begin
      case (scc_pkg::cfg_idx_t'(cfg_if.index))
        scc_pkg::CFG_WINDOW: window_r <= cfg_if.data[scc_pkg::WIN_W-1:0];
        scc_pkg::CFG_FS:     fs_r     <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ flow control
  // pending counts block ends accepted and not yet delivered
  assign in_if.ready = (pending_r < scc_pkg::FCNT_W'(scc_pkg::OUT_FIFO_DEPTH));
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_fire    = out_if.valid && out_if.ready;

  always_comb begin
    pending_nxt = pending_r;
    if (in_fire && in_if.last_in_block) begin
      pending_nxt = pending_nxt + 1'b1;
    end
    if (out_fire) begin
      pending_nxt = pending_nxt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  // --------------------------------------------------------------- datapath
  scc_corr u_corr (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_fire),
    .sample_re     (in_if.sample_re),
    .sample_im     (in_if.sample_im),
    .antenna       (in_if.antenna),
    .coarse_mode   (in_if.coarse_mode),
    .last_in_row   (in_if.last_in_row),
    .last_in_block (in_if.last_in_block),
    .window_length (window_r),
    .row_o         (row)
  );

  scc_select u_select (
    .clk   (clk),
    .rst_n (rst_n),
    .row_i (row),
    .blk_o (blk)
  );

  scc_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .blk_i (blk),
    .ang_o (ang)
  );

  scc_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .ang_i (ang),
    .fs    (fs_r),
    .res_o (res)
  );

  // ----------------------------------------------------------- result queue
  assign push = res.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fcnt_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fcnt_r <= fcnt_r + scc_pkg::FCNT_W'(push) - scc_pkg::FCNT_W'(out_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= res;
    end
  end

  assign out_if.valid            = (fcnt_r != '0);
  assign out_if.cfo_hz           = fifo_r[rd_ptr_r].cfo;
  assign out_if.selected_antenna = fifo_r[rd_ptr_r].antenna;

  // ------------------------------------------------------------- assertions
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (fcnt_r < scc_pkg::FCNT_W'(scc_pkg::OUT_FIFO_DEPTH)))
    else $error("result queue overflow");

  a_queue_covered: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= pending_r)
    else $error("queued results exceed pending block ends");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r == fcnt_r) |-> !push)
    else $error("result produced without a pending block end");

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= scc_pkg::FCNT_W'(scc_pkg::OUT_FIFO_DEPTH))
    else $error("pending transaction count out of range");

endmodule

>>> tb/sv/scc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_checker
// Watches the sample, result and configuration channels of the CFO
// estimator, predicts each block's offset and kept antenna, and compares
// every result transaction in order against the prediction.
// ----------------------------------------------------------------------------
module scc_checker
  import scc_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_re,
  input  logic signed [SAMPLE_BITS-1:0] in_im,
  input  logic [ANT_W-1:0]              in_ant,
  input  logic                          in_coarse,
  input  logic                          in_row_end,
  input  logic                          in_block_end,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [CFO_W-1:0]       out_cfo,
  input  logic [ANT_W-1:0]              out_ant,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [FS_W-1:0]               cfg_data,
  output int                            fail_count,
  output int                            pending
);

  typedef struct packed {
    logic signed [CFO_W-1:0] cfo;
    logic [ANT_W-1:0]        ant;
  } cfo_result_t;

  localparam longint ATAN_TURNS [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  cfo_result_t             cfo_expected_q[$];
  int                      mismatches;
  logic [WIN_W-1:0]        win_len;
  logic [FS_W-1:0]         fs_hz;
  longint                  hist_re [FINE_DELAY];
  longint                  hist_im [FINE_DELAY];
  int unsigned             row_pos;
  logic signed [ACC_W-1:0] sh_re, sh_im, lg_re, lg_im;
  logic signed [ACC_W-1:0] kept_sh_re, kept_sh_im, kept_lg_re, kept_lg_im;
  logic [127:0]            kept_power;
  logic [ANT_W-1:0]        kept_ant;

  function automatic void correlate(input int unsigned p, input int unsigned d,
                                    input int unsigned w, input longint br,
                                    input longint bi,
                                    inout logic signed [ACC_W-1:0] re,
                                    inout logic signed [ACC_W-1:0] im);
    longint ar, ai;
    if (p < d || p - d >= w) return;
    ar = hist_re[(p - d) % FINE_DELAY];
    ai = hist_im[(p - d) % FINE_DELAY];
    re = re + ACC_W'(ar * br + ai * bi);
    im = im + ACC_W'(ai * br - ar * bi);
  endfunction

  function automatic logic [127:0] square(input logic signed [ACC_W-1:0] v);
    longint a;
    a = v;
    if (a < 0) a = -a;
    return 128'(a) * 128'(a);
  endfunction

  // Vectoring rotation; the angle comes back in 2^-32 turn units.
  function automatic longint phase_turns(input longint x, input longint y);
    longint z, xn;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? (longint'(1) <<< 31) : -(longint'(1) <<< 31);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (y > 0) begin
        xn = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ATAN_TURNS[i];
      end else begin
        xn = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ATAN_TURNS[i];
      end
      x = xn;
    end
    return z;
  endfunction

  function automatic void clear_block();
    sh_re = '0; sh_im = '0; lg_re = '0; lg_im = '0; row_pos = 0;
    kept_sh_re = '0; kept_sh_im = '0; kept_lg_re = '0; kept_lg_im = '0;
    kept_power = '0; kept_ant = '0;
  endfunction

  function automatic void predict_sample();
    longint              br, bi, ang, res;
    longint unsigned     num, quo, den;
    logic [127:0]        pw;
    cfo_result_t         r;
    br = in_re;
    bi = in_im;
    if (in_coarse) begin
      correlate(row_pos, COARSE_DELAY, win_len + COARSE_DELAY, br, bi, sh_re, sh_im);
      correlate(row_pos, 2 * COARSE_DELAY, win_len + COARSE_DELAY, br, bi,
                lg_re, lg_im);
    end else begin
      correlate(row_pos, FINE_DELAY, win_len, br, bi, sh_re, sh_im);
    end
    hist_re[row_pos % FINE_DELAY] = br;
    hist_im[row_pos % FINE_DELAY] = bi;
    row_pos = (row_pos + 1) % 512;
    if (in_row_end || in_block_end) begin
      pw = square(sh_re) + square(sh_im);
      // strictly larger only: ties keep the earlier row
      if (in_ant < MAX_ANTENNAS && pw > kept_power) begin
        kept_power = pw;
        kept_sh_re = sh_re; kept_sh_im = sh_im;
        kept_lg_re = lg_re; kept_lg_im = lg_im;
        kept_ant   = in_ant;
      end
      sh_re = '0; sh_im = '0; lg_re = '0; lg_im = '0; row_pos = 0;
    end
    if (in_block_end) begin
      ang = phase_turns(kept_sh_re, kept_sh_im);
      if (in_coarse) ang = 2 * ang + phase_turns(kept_lg_re, kept_lg_im);
      den = longint'(FINE_DELAY) << 32;
      num = longint'(ang < 0 ? -ang : ang) * longint'(fs_hz);
      quo = (num + den / 2) / den;
      if (quo > 4194304) quo = 4194304;
      res = (ang < 0) ? longint'(quo) : -longint'(quo);
      if (res > 4194303) res = 4194303;
      r.cfo = CFO_W'(res);
      r.ant = kept_ant;
      cfo_expected_q.push_back(r);
      clear_block();
    end
  endfunction

  always @(posedge clk) begin
    cfo_result_t e;
    if (!rst_n) begin
      win_len = WIN_RESET;
      fs_hz   = FS_RESET;
      clear_block();
      cfo_expected_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WINDOW) win_len = cfg_data[WIN_W-1:0];
        else fs_hz = cfg_data;
      end
      if (in_valid && in_ready) predict_sample();
      if (out_valid && out_ready) begin
        if (cfo_expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result cfo=%0d ant=%0d", $realtime, out_cfo, out_ant);
        end else begin
          e = cfo_expected_q.pop_front();
          if (e.cfo !== out_cfo || e.ant !== out_ant) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch cfo exp %0d got %0d, ant exp %0d got %0d",
                       $realtime, e.cfo, out_cfo, e.ant, out_ant);
          end
        end
      end
    end
    fail_count <= mismatches;
    pending    <= cfo_expected_q.size();
  end

endmodule

>>> tb/sv/schmidl_cox_cfo_estimator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// schmidl_cox_cfo_estimator_tb
// Drives preamble rows and blocks into the CFO estimator under several
// window and sample-rate settings, with random idling on both sides and a
// long output stall; the checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module schmidl_cox_cfo_estimator_tb;
  import scc_pkg::*;

  logic clk;
  logic rst_n;

  scc_in_if  in_ch ();
  scc_out_if out_ch ();
  scc_cfg_if cfg_ch ();

  int fail_count;
  int pending;
  int tx_idle_pct;
  int rx_idle_pct;
  int n_items;
  int n_blocks;
  bit hold_start;
  bit hold_on;

  // Row under construction; kept so a later row can repeat it for a tie.
  logic signed [SAMPLE_BITS-1:0] row_re[$];
  logic signed [SAMPLE_BITS-1:0] row_im[$];

  schmidl_cox_cfo_estimator u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  scc_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_re        (in_ch.sample_re),
    .in_im        (in_ch.sample_im),
    .in_ant       (in_ch.antenna),
    .in_coarse    (in_ch.coarse_mode),
    .in_row_end   (in_ch.last_in_row),
    .in_block_end (in_ch.last_in_block),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_cfo      (out_ch.cfo_hz),
    .out_ant      (out_ch.selected_antenna),
    .cfg_valid    (cfg_ch.valid),
    .cfg_ready    (cfg_ch.ready),
    .cfg_index    (cfg_ch.index),
    .cfg_data     (cfg_ch.data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: random back-pressure, plus a long hold-off on request.
  always @(posedge clk) begin
    out_ch.ready <= !hold_on && ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    hold_on = 1'b0;
    wait (hold_start);
    @(posedge clk);
    hold_on = 1'b1;
    repeat (600) @(posedge clk);
    hold_on = 1'b0;
  end

  // Offer one sample transaction and hold it until it is accepted.
  task automatic send(input logic signed [SAMPLE_BITS-1:0] re,
                      input logic signed [SAMPLE_BITS-1:0] im,
                      input logic [ANT_W-1:0] ant, input logic coarse,
                      input logic row_end, input logic block_end);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.sample_re     <= re;
    in_ch.sample_im     <= im;
    in_ch.antenna       <= ant;
    in_ch.coarse_mode   <= coarse;
    in_ch.last_in_row   <= row_end;
    in_ch.last_in_block <= block_end;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_items++;
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [FS_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every predicted result, then let the pipeline settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
  endtask

  // Build a row: silent, extreme, wideband noise, or a periodic preamble
  // with a little noise so the delayed correlation has a real phase.
  task automatic fill_row(input int len);
    int kind, sh;
    logic signed [SAMPLE_BITS-1:0] per_re[16], per_im[16];
    logic signed [SAMPLE_BITS-1:0] ext[4];
    ext = '{16'sh7fff, -16'sh8000, 16'sh0000, -16'sh0001};
    kind = $urandom_range(9);
    sh   = $urandom_range(0, 8);
    foreach (per_re[k]) begin
      per_re[k] = $signed(16'($urandom)) >>> sh;
      per_im[k] = $signed(16'($urandom)) >>> sh;
    end
    row_re.delete();
    row_im.delete();
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: begin
          row_re.push_back('0);
          row_im.push_back('0);
        end
        1: begin
          row_re.push_back(ext[$urandom_range(3)]);
          row_im.push_back(ext[$urandom_range(3)]);
        end
        2, 3: begin
          row_re.push_back(16'($urandom));
          row_im.push_back(16'($urandom));
        end
        default: begin
          row_re.push_back(per_re[i % 16] + 16'($signed(4'($urandom))));
          row_im.push_back(per_im[i % 16] + 16'($signed(4'($urandom))));
        end
      endcase
    end
  endtask

  task automatic send_row(input logic [ANT_W-1:0] ant, input logic coarse,
                          input logic block_end, input bit flip);
    logic c, last;
    for (int i = 0; i < row_re.size(); i++) begin
      c    = coarse ^ (flip && $urandom_range(19) == 0);
      last = (i == row_re.size() - 1);
      // a block end may come without the row-end flag
      send(row_re[i], row_im[i], ant, c,
           last && (!block_end || $urandom_range(1)), last && block_end);
    end
  endtask

  // One block of one to four rows (at most two for wide windows); rows are
  // mostly long enough to fill the correlation window, sometimes cut short
  // or repeated for a tie.
  task automatic send_block(input int win);
    int nrows, full, len;
    logic coarse;
    bit flip;
    nrows  = (win > 96) ? $urandom_range(1, 2) : $urandom_range(1, 4);
    coarse = 1'($urandom_range(1));
    flip   = ($urandom_range(3) == 0);
    full   = coarse ? win + 3 * COARSE_DELAY : win + FINE_DELAY;
    for (int r = 0; r < nrows; r++) begin
      if (r == 0 || $urandom_range(4) != 0) begin
        len = ($urandom_range(3) == 0) ? $urandom_range(1, full + 4)
                                       : full + $urandom_range(0, 4);
        fill_row(len);
      end
      send_row(ANT_W'($urandom_range(3)), coarse, r == nrows - 1, flip);
    end
    n_blocks++;
  endtask

  initial begin
    int win_set[5];
    int fs_set[5];
    int start_items;

    // Every input known from time zero; reset held active low at the start.
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.sample_re     = '0;
    in_ch.sample_im     = '0;
    in_ch.antenna       = '0;
    in_ch.coarse_mode   = 1'b0;
    in_ch.last_in_row   = 1'b0;
    in_ch.last_in_block = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = CFG_WINDOW;
    cfg_ch.data         = '0;
    hold_start          = 1'b0;
    tx_idle_pct         = 11;
    rx_idle_pct         = 58;
    n_items             = 0;
    n_blocks            = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: an empty block reports 0 Hz on antenna 0, then a coarse
    // block of full-scale samples on the top antenna with the shortest window.
    cfg_write(CFG_WINDOW, FS_W'(1));
    send('0, '0, '0, 1'b0, 1'b1, 1'b1);
    for (int i = 0; i < 22; i++)
      send((i % 3 == 0) ? 16'sh7fff : (i % 3 == 1) ? -16'sh8000 : 16'sh0001,
           (i % 2 == 0) ? -16'sh8000 : 16'sh7fff,
           ANT_W'(3), 1'b1, i == 21, i == 21);
    drain();

    // Settings: narrowest and widest extremes, the reset values, random ones.
    win_set = '{1, 192, 64, $urandom_range(2, 32), $urandom_range(1, 24)};
    fs_set  = '{1000000, 80000000, 20000000,
                $urandom_range(1000000, 80000000), $urandom_range(1000000, 80000000)};

    for (int ph = 0; ph < 5; ph++) begin
      cfg_write(CFG_WINDOW, FS_W'(win_set[ph]));
      cfg_write(CFG_FS, FS_W'(fs_set[ph]));
      // Sender light/receiver heavy, then swapped, then no idling at all.
      if (ph < 2) begin
        tx_idle_pct = 11; rx_idle_pct = 58;
      end else if (ph < 4) begin
        tx_idle_pct = 58; rx_idle_pct = 11;
      end else begin
        tx_idle_pct = 0; rx_idle_pct = 0;
      end

      // Stall the result side for a long stretch while one-sample blocks
      // keep coming, so the result queue fills and the input backs up.
      if (ph == 2) begin
        hold_start = 1'b1;
        for (int k = 0; k < 60; k++)
          send(16'($urandom), 16'($urandom), ANT_W'($urandom_range(3)),
               1'($urandom_range(1)), 1'b1, 1'b1);
        n_blocks += 60;
        drain();
        // one row long enough to wrap the row position
        fill_row(530);
        send_row(ANT_W'(2), 1'b0, 1'b1, 1'b0);
        n_blocks++;
        drain();
      end

      start_items = n_items;
      while (n_items - start_items < 100)
        send_block(win_set[ph]);
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
